/* rtl/nfars_pkg.sv */
// Shared types, codes and helpers for the NFA regex search block.
package nfars_pkg;

  localparam int INST_MAX = 64;
  localparam int TEXT_MAX = 1024;
  localparam int PC_W     = 6;
  localparam int LEN_W    = 11;
  localparam int TADDR_W  = 10;

  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] UNDERSCORE = 8'h5F;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [3:0] OP_MATCH   = 4'd0;
  localparam logic [3:0] OP_BYTE    = 4'd1;
  localparam logic [3:0] OP_RANGE   = 4'd2;
  localparam logic [3:0] OP_ANY_NNL = 4'd3;
  localparam logic [3:0] OP_ANY     = 4'd4;
  localparam logic [3:0] OP_NOP     = 4'd5;
  localparam logic [3:0] OP_ALT     = 4'd6;
  localparam logic [3:0] OP_CAPTURE = 4'd7;
  localparam logic [3:0] OP_ASSERT  = 4'd8;
  localparam logic [3:0] OP_FAIL    = 4'd9;

  typedef struct packed {
    logic [3:0]      op;
    logic [PC_W-1:0] nm;
    logic [PC_W-1:0] na;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic [5:0]      af;
  } inst_t;

  // text context at the current position
  typedef struct packed {
    logic       at_begin;
    logic       at_end;
    logic       bol;
    logic       eol;
    logic       left_word;
    logic       cur_word;
    logic [7:0] cur_byte;
  } ctx_t;

  typedef struct packed {
    logic is_match;
    logic eps_main;
    logic eps_alt;
    logic take;
  } step_t;

  function automatic logic word_byte(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == UNDERSCORE;
  endfunction

  function automatic logic [PC_W-1:0] low_index(logic [INST_MAX-1:0] m);
    logic [PC_W-1:0] r;
    r = '0;
    for (int i = INST_MAX - 1; i >= 0; i--) begin
      if (m[i]) r = PC_W'(i);
    end
    return r;
  endfunction

endpackage

/* rtl/nfars_if.sv */
// Valid/ready channel interfaces for input items and search results.
interface nfars_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] inst_index;
  logic [3:0] opcode;
  logic [5:0] next_main;
  logic [5:0] next_alt;
  logic [7:0] range_low;
  logic [7:0] range_high;
  logic [5:0] assert_flags;
  logic [7:0] text_byte;
  modport source(output valid, func, inst_index, opcode, next_main, next_alt,
                 range_low, range_high, assert_flags, text_byte, input ready);
  modport sink(input valid, func, inst_index, opcode, next_main, next_alt,
               range_low, range_high, assert_flags, text_byte, output ready);
endinterface

interface nfars_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [10:0] hit_start;
  logic [10:0] hit_end;
  logic        text_overflow;
  modport source(output valid, found, hit_start, hit_end, text_overflow,
                 input ready);
  modport sink(input valid, found, hit_start, hit_end, text_overflow,
               output ready);
endinterface

/* rtl/nfars_prog_mem.sv */
// Program store: one write port, one registered read port.
module nfars_prog_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [nfars_pkg::PC_W-1:0] waddr,
  input  nfars_pkg::inst_t         wdata,
  input  logic [nfars_pkg::PC_W-1:0] raddr,
  output nfars_pkg::inst_t         rdata
);
  nfars_pkg::inst_t mem [nfars_pkg::INST_MAX];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/nfars_text_mem.sv */
// Text buffer: one write port, one registered read port.
module nfars_text_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [nfars_pkg::TADDR_W-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [nfars_pkg::TADDR_W-1:0] raddr,
  output logic [7:0]                  rdata
);
  logic [7:0] mem [nfars_pkg::TEXT_MAX];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/nfars_step_unit.sv */
// Evaluates one instruction against the text context: epsilon edges and byte test.
module nfars_step_unit (
  input  nfars_pkg::inst_t inst,
  input  nfars_pkg::ctx_t  ctx,
  output nfars_pkg::step_t step
);
  logic assert_ok;
  logic c_eq, c_in;

  always_comb begin
    assert_ok = !(inst.af[0] && !ctx.at_begin) && !(inst.af[1] && !ctx.at_end) &&
                !(inst.af[2] && !ctx.bol) && !(inst.af[3] && !ctx.eol) &&
                !(inst.af[4] && ctx.left_word == ctx.cur_word) &&
                !(inst.af[5] && ctx.left_word != ctx.cur_word);
    c_eq = ctx.cur_byte == inst.lo;
    c_in = ctx.cur_byte >= inst.lo && ctx.cur_byte <= inst.hi;
    step = '0;
    case (inst.op) inside
      nfars_pkg::OP_MATCH:                      step.is_match = 1'b1;
      nfars_pkg::OP_BYTE:                       step.take     = c_eq;
      nfars_pkg::OP_RANGE:                      step.take     = c_in;
      nfars_pkg::OP_ANY_NNL:                    step.take     = ctx.cur_byte != nfars_pkg::NL_BYTE;
      nfars_pkg::OP_ANY:                        step.take     = 1'b1;
      nfars_pkg::OP_NOP, nfars_pkg::OP_CAPTURE: step.eps_main = 1'b1;
      nfars_pkg::OP_ALT: begin
        step.eps_main = 1'b1;
        step.eps_alt  = 1'b1;
      end
      nfars_pkg::OP_ASSERT:                     step.eps_main = assert_ok;
      default:                                  step = '0;
    endcase
  end
endmodule

/* rtl/nfars_seq.sv */
// Search sequencer: walks start positions, closures and byte steps one instruction at a time.
module nfars_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [nfars_pkg::PC_W-1:0]  start_pc,
  input  logic [nfars_pkg::LEN_W-1:0] len,
  input  logic [7:0]                  text_rdata,
  output logic [nfars_pkg::TADDR_W-1:0] text_raddr,
  output logic [nfars_pkg::PC_W-1:0]  prog_raddr,
  input  nfars_pkg::inst_t            prog_rdata,
  input  logic                        res_take,
  output logic                        busy,
  output logic                        res_ready,
  output logic                        res_found,
  output logic [nfars_pkg::LEN_W-1:0] res_start,
  output logic [nfars_pkg::LEN_W-1:0] res_end
);
  typedef enum logic [3:0] {
    S_IDLE, S_FP, S_FC, S_FW, S_CPICK, S_CEXEC, S_APICK, S_AEXEC, S_DONE
  } state_t;

  localparam int N = nfars_pkg::INST_MAX;

  state_t                      state;
  logic [nfars_pkg::LEN_W-1:0] pos, s;
  logic [N-1:0]                vset, pend, scan;
  logic                        mflag, have;
  logic [nfars_pkg::LEN_W-1:0] mend;
  logic [7:0]                  prev_byte, cur_byte;
  logic [nfars_pkg::PC_W-1:0]  pick_c, pick_a;
  logic                        have_now;
  logic [nfars_pkg::LEN_W-1:0] end_now;
  nfars_pkg::ctx_t             ctx;
  nfars_pkg::step_t            step;

  function automatic logic [nfars_pkg::TADDR_W-1:0] TADDR_CUT(
      logic [nfars_pkg::LEN_W-1:0] v);
    return v[nfars_pkg::TADDR_W-1:0];
  endfunction

  always_comb begin
    ctx.at_begin  = pos == '0;
    ctx.at_end    = pos == len;
    ctx.bol       = ctx.at_begin || prev_byte == nfars_pkg::NL_BYTE;
    ctx.eol       = ctx.at_end || cur_byte == nfars_pkg::NL_BYTE;
    ctx.left_word = !ctx.at_begin && nfars_pkg::word_byte(prev_byte);
    ctx.cur_word  = (pos < len) && nfars_pkg::word_byte(cur_byte);
    ctx.cur_byte  = cur_byte;
    pick_c        = nfars_pkg::low_index(pend);
    pick_a        = nfars_pkg::low_index(scan);
    prog_raddr    = (state == S_APICK) ? pick_a : pick_c;
    text_raddr    = (state == S_FP) ? TADDR_CUT(pos - 1'b1) : TADDR_CUT(pos);
    have_now      = have || mflag;
    end_now       = mflag ? pos : mend;
    busy          = state != S_IDLE;
  end

  nfars_step_unit u_step (.inst(prog_rdata), .ctx(ctx), .step(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_ready <= 1'b0;
      vset      <= '0;
      pend      <= '0;
      scan      <= '0;
      mflag     <= 1'b0;
      have      <= 1'b0;
    end else begin
      res_ready <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            s     <= '0;
            pos   <= '0;
            vset  <= '0;
            pend  <= N'(1) << start_pc;
            mflag <= 1'b0;
            have  <= 1'b0;
            state <= S_FP;
          end
        end
        S_FP: state <= S_FC;
        S_FC: begin
          prev_byte <= text_rdata;
          state     <= S_FW;
        end
        S_FW: begin
          cur_byte <= text_rdata;
          state    <= S_CPICK;
        end
        S_CPICK: begin
          if (pend != '0) begin
            pend[pick_c] <= 1'b0;
            if (!vset[pick_c]) begin
              vset[pick_c] <= 1'b1;
              state        <= S_CEXEC;
            end
          end else if (vset != '0 && pos < len) begin
            // closure done, set alive: step over the next byte
            have  <= have_now;
            mend  <= end_now;
            scan  <= vset;
            state <= S_APICK;
          end else if (have_now) begin
            res_found <= 1'b1;
            res_start <= s;
            res_end   <= end_now;
            state     <= S_DONE;
          end else if (s == len) begin
            res_found <= 1'b0;
            res_start <= '0;
            res_end   <= '0;
            state     <= S_DONE;
          end else begin
            // advance to the next start position
            s     <= s + 1'b1;
            pos   <= s + 1'b1;
            vset  <= '0;
            pend  <= N'(1) << start_pc;
            mflag <= 1'b0;
            have  <= 1'b0;
            state <= S_FP;
          end
        end
        S_CEXEC: begin
          if (step.is_match) mflag <= 1'b1;
          pend <= pend | (step.eps_main ? (N'(1) << prog_rdata.nm) : '0)
                       | (step.eps_alt  ? (N'(1) << prog_rdata.na) : '0);
          state <= S_CPICK;
        end
        S_APICK: begin
          if (scan != '0) begin
            scan[pick_a] <= 1'b0;
            state        <= S_AEXEC;
          end else begin
            pos   <= pos + 1'b1;
            vset  <= '0;
            mflag <= 1'b0;
            state <= S_FP;
          end
        end
        S_AEXEC: begin
          if (step.take) pend <= pend | (N'(1) << prog_rdata.nm);
          state <= S_APICK;
        end
        S_DONE: begin
          if (res_take) begin
            res_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/nfa_regex_leftmost_longest_search.sv */
// Top level of the NFA regex search block: channels, buffers and result register.
// Usage:
//   in_ch carries items: func 0 loads one instruction into the program store,
//   func 1 appends one text byte, func 2 ends the text and runs the search.
//   Load and append beats, taken one per cycle outside a search, give no result.
//   A search beat drops ready; one result beat then leaves on out_ch (found,
//   hit_start, hit_end, text_overflow), and ready rises again in the cycle
//   that beat appears. Search work: for every start tried, each position
//   passes through a text fetch (S_FP, S_FC, S_FW), a pick of each pending pc
//   with an evaluation of each newly visited instruction and a closing pick,
//   then a pick and an evaluation of each live instruction and a closing
//   pick in the byte step; all of it runs through one program-store read
//   port and one instruction evaluator.
//   Bytes appended past 1024 are dropped and flagged in text_overflow.
//   After a search the text length and overflow flag clear; program and
//   start_pc stay. The user lets cfg_we write start_pc only while the block is
//   idle; the block does not enforce it. Reset (rst, synchronous) empties the
//   text, clears start_pc and the flag. The program store holds no reset value.
//   A stalled out_ch holds its beat and load and append beats keep flowing;
//   a search that finishes meanwhile holds in_ch not ready until the beat leaves.
module nfa_regex_leftmost_longest_search (
  input  logic          clk,
  input  logic          rst,
  nfars_in_if.sink      in_ch,
  nfars_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_wdata
);
  logic [nfars_pkg::PC_W-1:0]  start_pc;
  logic [nfars_pkg::LEN_W-1:0] len;
  logic                        ovf;
  logic                        acc, busy, res_ready, res_take;
  logic                        res_found;
  logic [nfars_pkg::LEN_W-1:0] res_start, res_end;
  logic [7:0]                  text_rdata;
  logic [nfars_pkg::TADDR_W-1:0] text_raddr;
  logic [nfars_pkg::PC_W-1:0]  prog_raddr;
  nfars_pkg::inst_t            prog_rdata, prog_wdata;
  logic                        room;

  // hold input off during a search and while the finished search hands over and clears the text
  assign in_ch.ready = !busy && !res_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign room        = len < nfars_pkg::LEN_W'(nfars_pkg::TEXT_MAX);
  assign res_take    = !out_ch.valid || out_ch.ready;

  assign prog_wdata.op = in_ch.opcode;
  assign prog_wdata.nm = in_ch.next_main;
  assign prog_wdata.na = in_ch.next_alt;
  assign prog_wdata.lo = in_ch.range_low;
  assign prog_wdata.hi = in_ch.range_high;
  assign prog_wdata.af = in_ch.assert_flags;

  nfars_prog_mem u_prog (
    .clk(clk), .we(acc && in_ch.func == nfars_pkg::FUNC_LOAD),
    .waddr(in_ch.inst_index), .wdata(prog_wdata),
    .raddr(prog_raddr), .rdata(prog_rdata));

  nfars_text_mem u_text (
    .clk(clk), .we(acc && in_ch.func == nfars_pkg::FUNC_APPEND && room),
    .waddr(len[nfars_pkg::TADDR_W-1:0]), .wdata(in_ch.text_byte),
    .raddr(text_raddr), .rdata(text_rdata));

  nfars_seq u_seq (
    .clk(clk), .rst(rst), .go(acc && in_ch.func == nfars_pkg::FUNC_SEARCH),
    .start_pc(start_pc), .len(len), .text_rdata(text_rdata),
    .text_raddr(text_raddr), .prog_raddr(prog_raddr), .prog_rdata(prog_rdata),
    .res_take(res_take), .busy(busy), .res_ready(res_ready),
    .res_found(res_found), .res_start(res_start), .res_end(res_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc     <= '0;
      len          <= '0;
      ovf          <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) start_pc <= cfg_wdata;
      if (res_ready) begin
        // load the result beat and drop the consumed text
        out_ch.valid         <= 1'b1;
        out_ch.found         <= res_found;
        out_ch.hit_start     <= res_start;
        out_ch.hit_end       <= res_end;
        out_ch.text_overflow <= ovf;
        len                  <= '0;
        ovf                  <= 1'b0;
      end else begin
        if (acc && in_ch.func == nfars_pkg::FUNC_APPEND) begin
          if (room) len <= len + 1'b1;
          else      ovf <= 1'b1;
        end
        if (out_ch.ready) out_ch.valid <= 1'b0;
      end
    end
  end

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.found |-> out_ch.hit_start == '0 && out_ch.hit_end == '0)
    else $error("no-match result carries nonzero offsets");

  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.found |-> out_ch.hit_end >= out_ch.hit_start)
    else $error("match end before match start");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= nfars_pkg::LEN_W'(nfars_pkg::TEXT_MAX))
    else $error("text length beyond buffer");

  a_text_cleared: assert property (@(posedge clk) disable iff (rst)
    res_ready |=> len == '0 && !ovf)
    else $error("text not cleared after search");
endmodule

/* tb/tb_top.sv */
// Testbench for the NFA regex search block: queued stimulus, predictor and result check.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1450;

  typedef enum logic { K_BEAT, K_SYNC } kind_t;

  typedef struct {
    kind_t      kind;
    logic       do_cfg;
    logic [5:0] cfg_val;
    logic [1:0] func;
    logic [5:0] idx;
    logic [3:0] op;
    logic [5:0] nm;
    logic [5:0] na;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [5:0] af;
    logic [7:0] tb;
    int         gap;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [10:0] mstart;
    logic [10:0] mend;
    logic        ovf;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  nfars_in_if  in_ch();
  nfars_out_if out_ch();

  nfa_regex_leftmost_longest_search uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  item_t   item_q[$];
  result_t result_q[$];
  int      errors = 0;
  int      cycles = 0;
  logic    in_beat = 0;
  logic    calm_in = 0;
  logic    calm_out = 0;

  // predictor state
  nfars_pkg::inst_t prog_mem[nfars_pkg::INST_MAX];
  logic [7:0]       txt[nfars_pkg::TEXT_MAX];
  int               txt_len = 0;
  logic             txt_ovf = 0;
  logic [5:0]       entry_pc = '0;

  function automatic logic is_word(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) || c == 8'h5F;
  endfunction

  function automatic logic cond_holds(logic [5:0] f, int pos, int len);
    logic pw, cw;
    pw = pos > 0 && is_word(txt[pos-1]);
    cw = pos < len && is_word(txt[pos]);
    if (f[0] && pos != 0) return 0;
    if (f[1] && pos != len) return 0;
    if (f[2] && pos != 0 && txt[pos-1] != nfars_pkg::NL_BYTE) return 0;
    if (f[3] && pos != len && txt[pos] != nfars_pkg::NL_BYTE) return 0;
    if (f[4] && pw == cw) return 0;
    if (f[5] && pw != cw) return 0;
    return 1;
  endfunction

  // add the epsilon closure of pc at pos to set s
  function automatic logic [nfars_pkg::INST_MAX-1:0] eps_close(
      logic [nfars_pkg::INST_MAX-1:0] s, int pc, int pos, int len);
    int               stk[$];
    int               x;
    nfars_pkg::inst_t ins;
    stk.push_back(pc);
    while (stk.size() > 0) begin
      x = stk.pop_back();
      if (x >= nfars_pkg::INST_MAX || s[x]) continue;
      s[x] = 1'b1;
      ins = prog_mem[x];
      case (ins.op)
        nfars_pkg::OP_NOP, nfars_pkg::OP_CAPTURE: stk.push_back(int'(ins.nm));
        nfars_pkg::OP_ALT: begin
          stk.push_back(int'(ins.na));
          stk.push_back(int'(ins.nm));
        end
        nfars_pkg::OP_ASSERT:
          if (cond_holds(ins.af, pos, len)) stk.push_back(int'(ins.nm));
        default: ;
      endcase
    end
    return s;
  endfunction

  function automatic result_t run_search();
    result_t r;
    logic [nfars_pkg::INST_MAX-1:0] cur, nxt;
    logic have, take;
    int t, last_end;
    logic [7:0] c;
    r = '0;
    r.ovf = txt_ovf;
    for (int s = 0; s <= txt_len; s++) begin
      have = 0;
      last_end = 0;
      cur = eps_close('0, int'(entry_pc), s, txt_len);
      t = s;
      while (cur != '0) begin
        for (int i = 0; i < nfars_pkg::INST_MAX; i++)
          if (cur[i] && prog_mem[i].op == nfars_pkg::OP_MATCH) begin
            have = 1;
            last_end = t;
          end
        if (t >= txt_len) break;
        c = txt[t];
        nxt = '0;
        for (int i = 0; i < nfars_pkg::INST_MAX; i++) begin
          if (!cur[i]) continue;
          case (prog_mem[i].op)
            nfars_pkg::OP_BYTE:    take = c == prog_mem[i].lo;
            nfars_pkg::OP_RANGE:   take = c >= prog_mem[i].lo && c <= prog_mem[i].hi;
            nfars_pkg::OP_ANY_NNL: take = c != nfars_pkg::NL_BYTE;
            nfars_pkg::OP_ANY:     take = 1;
            default:               take = 0;
          endcase
          if (take) nxt = eps_close(nxt, int'(prog_mem[i].nm), t + 1, txt_len);
        end
        cur = nxt;
        t++;
      end
      if (have) begin
        r.found = 1;
        r.mstart = 11'(s);
        r.mend = 11'(last_end);
        return r;
      end
    end
    return r;
  endfunction

  // monitor and predictor
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      in_beat <= in_ch.valid && in_ch.ready;
      if (cfg_we) entry_pc = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          nfars_pkg::FUNC_LOAD: prog_mem[in_ch.inst_index] = '{op: in_ch.opcode,
              nm: in_ch.next_main, na: in_ch.next_alt, lo: in_ch.range_low,
              hi: in_ch.range_high, af: in_ch.assert_flags};
          nfars_pkg::FUNC_APPEND: begin
            if (txt_len < nfars_pkg::TEXT_MAX) begin
              txt[txt_len] = in_ch.text_byte;
              txt_len++;
            end else txt_ovf = 1;
          end
          nfars_pkg::FUNC_SEARCH: begin
            result_q.push_back(run_search());
            txt_len = 0;
            txt_ovf = 0;
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = result_q.pop_front();
          if (out_ch.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_ch.found);
            errors++;
          end
          if (out_ch.hit_start !== e.mstart) begin
            $error("hit_start: expected %0d, got %0d", e.mstart, out_ch.hit_start);
            errors++;
          end
          if (out_ch.hit_end !== e.mend) begin
            $error("hit_end: expected %0d, got %0d", e.mend, out_ch.hit_end);
            errors++;
          end
          if (out_ch.text_overflow !== e.ovf) begin
            $error("text_overflow: expected %0d, got %0d", e.ovf, out_ch.text_overflow);
            errors++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver
  int gap_left = 0;
  int hold = 0;
  always @(negedge clk) begin
    logic v, we;
    item_t it;
    v = in_ch.valid && !in_beat;
    we = 0;
    if (rst) v = 0;
    else if (!v) begin
      if (gap_left > 0) gap_left--;
      else if (item_q.size() > 0) begin
        it = item_q[0];
        if (it.kind == K_BEAT) begin
          void'(item_q.pop_front());
          in_ch.func <= it.func;
          in_ch.inst_index <= it.idx;
          in_ch.opcode <= it.op;
          in_ch.next_main <= it.nm;
          in_ch.next_alt <= it.na;
          in_ch.range_low <= it.lo;
          in_ch.range_high <= it.hi;
          in_ch.assert_flags <= it.af;
          in_ch.text_byte <= it.tb;
          gap_left = it.gap;
          v = 1;
        end else if (result_q.size() == 0) begin
          // let the block settle before touching the register
          if (hold < HOLD_CYCLES) hold++;
          else begin
            hold = 0;
            void'(item_q.pop_front());
            if (it.do_cfg) begin
              we = 1;
              cfg_wdata <= it.cfg_val;
            end
          end
        end
      end
    end
    in_ch.valid <= v;
    cfg_we <= we;
  end

  // result sink with random stalls
  int stall = 0;
  always @(negedge clk) begin
    logic r;
    if (stall > 0) begin
      stall--;
      r = 0;
    end else begin
      r = 1;
      if (!calm_out && $urandom_range(0, 3) == 0) stall = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
    out_ch.ready <= r;
  end

  function automatic item_t blank(logic [1:0] f);
    item_t it;
    it = '{kind: K_BEAT, do_cfg: 0, cfg_val: '0, func: f, idx: '0, op: '0, nm: '0,
           na: '0, lo: '0, hi: '0, af: '0, tb: '0, gap: 0};
    if (!calm_in) it.gap = pick_gap();
    return it;
  endfunction

  task automatic put_load(int idx, logic [3:0] op, int nm, int na, int lo, int hi, int af);
    item_t it;
    it = blank(nfars_pkg::FUNC_LOAD);
    it.idx = 6'(idx);
    it.op = op;
    it.nm = 6'(nm);
    it.na = 6'(na);
    it.lo = 8'(lo);
    it.hi = 8'(hi);
    it.af = 6'(af);
    item_q.push_back(it);
  endtask

  task automatic put_byte(logic [7:0] b);
    item_t it;
    it = blank(nfars_pkg::FUNC_APPEND);
    it.tb = b;
    item_q.push_back(it);
  endtask

  task automatic put_search();
    item_q.push_back(blank(nfars_pkg::FUNC_SEARCH));
  endtask

  task automatic put_sync(logic do_cfg, logic [5:0] val);
    item_t it;
    it = blank(nfars_pkg::FUNC_LOAD);
    it.kind = K_SYNC;
    it.do_cfg = do_cfg;
    it.cfg_val = val;
    item_q.push_back(it);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] alpha[7] = '{8'h61, 8'h62, 8'h5F, 8'h30, 8'h20, nfars_pkg::NL_BYTE,
                             8'h5A};
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return alpha[$urandom_range(0, 6)];
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return nfars_pkg::OP_MATCH;
    if (r < 30) return nfars_pkg::OP_BYTE;
    if (r < 42) return nfars_pkg::OP_RANGE;
    if (r < 50) return nfars_pkg::OP_ANY_NNL;
    if (r < 55) return nfars_pkg::OP_ANY;
    if (r < 63) return nfars_pkg::OP_NOP;
    if (r < 78) return nfars_pkg::OP_ALT;
    if (r < 83) return nfars_pkg::OP_CAPTURE;
    if (r < 93) return nfars_pkg::OP_ASSERT;
    if (r < 96) return nfars_pkg::OP_FAIL;
    return 4'($urandom_range(10, 15));
  endfunction

  function automatic int pick_flags();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 1 << $urandom_range(0, 5);
    if (r < 8) return 0;
    return $urandom_range(0, 63);
  endfunction

  task automatic put_rand_load(int idx);
    logic [7:0] a, b;
    a = pick_char();
    b = $urandom_range(0, 3) == 0 ? 8'($urandom) : a + 8'($urandom_range(0, 30));
    put_load(idx, pick_op(), $urandom_range(0, 63), $urandom_range(0, 63), a, b,
             pick_flags());
  endtask

  task automatic build_stimulus();
    int    n, len;
    string demo;
    // a(b..d)* followed by a word boundary, captured
    put_load(0, nfars_pkg::OP_BYTE, 1, 0, 8'h61, 0, 0);
    put_load(1, nfars_pkg::OP_ALT, 2, 3, 0, 0, 0);
    put_load(2, nfars_pkg::OP_RANGE, 1, 0, 8'h62, 8'h64, 0);
    put_load(3, nfars_pkg::OP_ASSERT, 4, 0, 0, 0, 16);
    put_load(4, nfars_pkg::OP_CAPTURE, 5, 0, 0, 0, 0);
    put_load(5, nfars_pkg::OP_MATCH, 0, 0, 8'hFF, 8'hFF, 63);
    demo = " abcb x";
    foreach (demo[i]) put_byte(demo[i]);
    put_search();
    // empty text, begin and end of text both hold
    put_load(0, nfars_pkg::OP_ASSERT, 5, 0, 0, 0, 3);
    put_search();
    // newline only: no match anywhere
    put_load(0, nfars_pkg::OP_ANY_NNL, 5, 0, 0, 0, 0);
    put_byte(nfars_pkg::NL_BYTE);
    put_search();
    // unused func code is ignored
    begin
      item_t it;
      it = blank(nfars_pkg::FUNC_UNUSED);
      it.tb = 8'hFF;
      item_q.push_back(it);
    end
    put_sync(0, '0);

    // full program fill so every slot is defined
    for (int i = 0; i < nfars_pkg::INST_MAX; i++) put_rand_load(i);
    n = nfars_pkg::INST_MAX;
    put_sync(1, 6'd63);
    // leave room in the item budget for the overflow run
    while (n < RANDOM_ITEMS - nfars_pkg::TEXT_MAX - 40) begin
      if ($urandom_range(0, 7) == 0) calm_in = !calm_in;
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: put_sync(1, 6'd0);
          1: put_sync(1, 6'd63);
          default: put_sync(1, 6'($urandom));
        endcase
      end else if ($urandom_range(0, 9) == 0) put_sync(0, '0);
      repeat ($urandom_range(0, 6)) begin
        put_rand_load($urandom_range(0, 63));
        n++;
      end
      len = $urandom_range(0, 99);
      len = len < 80 ? $urandom_range(0, 6) : len < 98 ? $urandom_range(7, 16)
          : $urandom_range(30, 60);
      repeat (len) put_byte(pick_char());
      n += len + 1;
      if ($urandom_range(0, 15) == 0) begin
        item_t it;
        it = blank(nfars_pkg::FUNC_UNUSED);
        it.idx = 6'($urandom);
        item_q.push_back(it);
      end
      put_search();
    end

    // overflow: a program that never matches over a full buffer
    put_sync(1, 6'd0);
    put_load(0, nfars_pkg::OP_BYTE, 1, 0, 8'h5A, 0, 0);
    repeat (nfars_pkg::TEXT_MAX + 6) put_byte(8'h61);
    put_search();
    put_search();
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.func = '0;
    in_ch.inst_index = '0;
    in_ch.opcode = '0;
    in_ch.next_main = '0;
    in_ch.next_alt = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    in_ch.assert_flags = '0;
    in_ch.text_byte = '0;
    out_ch.ready = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    for (int i = 0; i < nfars_pkg::INST_MAX; i++) prog_mem[i] = '0;
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    while (item_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
